@@ hw/rtl/bcdt_pkg.sv @@
// Package for the BCD time-of-day alarm calculator.
// Holds field widths, mode and status codes, and the BCD conversion functions.
// Depends on nothing.
`default_nettype none

package bcdt_pkg;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned TimeW   = 22;
  localparam int unsigned SecW    = 17;
  localparam int unsigned StatusW = 2;

  localparam logic [SecW-1:0] DaySeconds  = 17'd86400;
  localparam logic [15:0]     HourRecip   = 16'd37283;
  localparam int unsigned     HourShift   = 27;
  localparam logic [12:0]     MinRecip    = 13'd4370;
  localparam int unsigned     MinShift    = 18;
  localparam logic [15:0]     TenRecip    = 16'hCCCD;

  typedef enum logic [ModeW-1:0] {
    MODE_SET   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_DELAY_BIG = 2'd1,
    STATUS_BAD_TIME  = 2'd2
  } status_e;

  typedef struct packed {
    logic [SecW-1:0] remaining;
    logic            armed;
    status_e         status;
  } res_t;

  function automatic logic time_is_valid(input logic [TimeW-1:0] t);
    logic [5:0] hours;
    hours = 6'({4'b0, t[21:20]} * 6'd10) + {2'b0, t[19:16]};
    return (t[19:16] <= 4'd9) && (t[11:8] <= 4'd9) && (t[3:0] <= 4'd9) &&
           (t[14:12] <= 3'd5) && (t[6:4] <= 3'd5) && (hours <= 6'd23);
  endfunction

  function automatic logic [17:0] bcd_to_seconds(input logic [TimeW-1:0] t);
    logic [5:0] h;
    logic [6:0] m;
    logic [6:0] s;
    h = 6'({4'b0, t[21:20]} * 6'd10) + {2'b0, t[19:16]};
    m = 7'({4'b0, t[14:12]} * 7'd10) + {3'b0, t[11:8]};
    s = 7'({4'b0, t[6:4]} * 7'd10) + {3'b0, t[3:0]};
    return 18'(18'(h) * 18'd3600) + 18'(18'(m) * 18'd60) + 18'(s);
  endfunction

  function automatic logic [7:0] two_digit_bcd(input logic [6:0] v);
    logic [22:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 23'(v) * 23'(TenRecip);
    q    = prod[22:19];
    r    = v - 7'(7'(q) * 7'd10);
    return {q, r[3:0]};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bcdt_if.sv @@
// Channel interfaces for the BCD time-of-day alarm calculator.
// Depends on bcdt_pkg for the field widths.
`default_nettype none

interface bcdt_in_if;
  logic                           valid;
  logic                           ready;
  logic [bcdt_pkg::ModeW-1:0]     mode;
  logic [bcdt_pkg::TimeW-1:0]     time_bcd;
  logic [bcdt_pkg::SecW-1:0]      delay_seconds;

  modport source (output valid, output mode, output time_bcd, output delay_seconds,
                  input ready);
  modport sink   (input valid, input mode, input time_bcd, input delay_seconds,
                  output ready);
endinterface

interface bcdt_out_if;
  logic                           valid;
  logic                           ready;
  logic [bcdt_pkg::TimeW-1:0]     alarm_bcd;
  logic [bcdt_pkg::SecW-1:0]      remaining_seconds;
  logic                           alarm_armed;
  logic [bcdt_pkg::StatusW-1:0]   status;

  modport source (output valid, output alarm_bcd, output remaining_seconds,
                  output alarm_armed, output status, input ready);
  modport sink   (input valid, input alarm_bcd, input remaining_seconds,
                  input alarm_armed, input status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bcd_time_of_day_alarm_calc.sv @@
// BCD time-of-day alarm calculator: set, query and clear of one alarm.
// Depends on bcdt_pkg and the channel interfaces in bcdt_if.
// Each accepted transaction passes through the registered stages A to E before its result is valid.
// Throughput: one transaction per cycle while the output is not stalled; the alarm state
// is updated in the second stage, so each item sees the state left by the one before it.
// Reset clears all stage valid bits, the stored alarm (00:00:00) and the armed flag.
`default_nettype none

module bcd_time_of_day_alarm_calc (
  input  wire         clk_i,
  input  wire         rst_ni,
  bcdt_in_if.sink     in_i,
  bcdt_out_if.source  out_o
);

  // Stage A: input register.
  logic                          a_valid_q;
  logic [bcdt_pkg::ModeW-1:0]    a_mode_q;
  logic [bcdt_pkg::TimeW-1:0]    a_time_q;
  logic [bcdt_pkg::SecW-1:0]     a_delay_q;

  // Stage B: state update, alarm in seconds travels with each item.
  logic                          b_valid_q;
  logic [bcdt_pkg::SecW-1:0]     b_alarm_q;
  bcdt_pkg::res_t                b_res_q;

  // Stage C: hours split off.
  logic                          c_valid_q;
  logic [4:0]                    c_hours_q;
  logic [11:0]                   c_rest_q;
  bcdt_pkg::res_t                c_res_q;

  // Stage D: minutes and seconds split.
  logic                          d_valid_q;
  logic [4:0]                    d_hours_q;
  logic [5:0]                    d_mins_q;
  logic [5:0]                    d_secs_q;
  bcdt_pkg::res_t                d_res_q;

  // Stage E: output register.
  logic                          e_valid_q;
  logic [bcdt_pkg::TimeW-1:0]    e_alarm_bcd_q;
  bcdt_pkg::res_t                e_res_q;

  // Architectural state.
  logic [bcdt_pkg::SecW-1:0]     alarm_sec_q, alarm_sec_d;
  logic                          armed_q, armed_d;

  logic a_ready, b_ready, c_ready, d_ready, e_ready;
  logic a_fire;

  assign e_ready  = !e_valid_q || out_o.ready;
  assign d_ready  = !d_valid_q || e_ready;
  assign c_ready  = !c_valid_q || d_ready;
  assign b_ready  = !b_valid_q || c_ready;
  assign a_ready  = !a_valid_q || b_ready;
  assign a_fire   = a_valid_q && b_ready;
  assign in_i.ready = a_ready;

  // Stage B logic.
  logic [17:0]               now_full;
  logic [bcdt_pkg::SecW-1:0] now_sec;
  logic [17:0]               sum;
  logic [17:0]               left;
  logic                      t_ok;
  bcdt_pkg::res_t            b_res_d;

  always_comb begin
    now_full    = bcdt_pkg::bcd_to_seconds(a_time_q);
    now_sec     = now_full[bcdt_pkg::SecW-1:0];
    t_ok        = bcdt_pkg::time_is_valid(a_time_q);
    sum         = 18'(now_sec) + 18'(a_delay_q);
    if (sum >= 18'(bcdt_pkg::DaySeconds)) begin
      sum = sum - 18'(bcdt_pkg::DaySeconds);
    end
    if (alarm_sec_q < now_sec) begin
      left = 18'(alarm_sec_q) + 18'(bcdt_pkg::DaySeconds) - 18'(now_sec);
    end else begin
      left = 18'(alarm_sec_q) - 18'(now_sec);
    end
    alarm_sec_d       = alarm_sec_q;
    armed_d           = armed_q;
    b_res_d.remaining = '0;
    b_res_d.status    = bcdt_pkg::STATUS_OK;
    unique case (bcdt_pkg::mode_e'(a_mode_q))
      bcdt_pkg::MODE_SET: begin
        if (!t_ok) begin
          b_res_d.status = bcdt_pkg::STATUS_BAD_TIME;
        end else if (a_delay_q >= bcdt_pkg::DaySeconds) begin
          b_res_d.status = bcdt_pkg::STATUS_DELAY_BIG;
        end else begin
          alarm_sec_d = sum[bcdt_pkg::SecW-1:0];
          armed_d     = 1'b1;
        end
      end
      bcdt_pkg::MODE_QUERY: begin
        if (!t_ok) begin
          b_res_d.status = bcdt_pkg::STATUS_BAD_TIME;
        end else if (armed_q) begin
          b_res_d.remaining = left[bcdt_pkg::SecW-1:0];
        end
      end
      bcdt_pkg::MODE_CLEAR: begin
        armed_d = 1'b0;
      end
      default: begin
      end
    endcase
    b_res_d.armed = armed_d;
  end

  // Stage C logic: divide by 3600 through a reciprocal multiply.
  logic [32:0] hour_prod;
  logic [4:0]  hours_c;
  logic [16:0] rest_c;

  always_comb begin
    hour_prod = 33'(b_alarm_q) * 33'(bcdt_pkg::HourRecip);
    hours_c   = hour_prod[bcdt_pkg::HourShift+4:bcdt_pkg::HourShift];
    rest_c    = b_alarm_q - 17'(17'(hours_c) * 17'd3600);
  end

  // Stage D logic: divide by 60 through a reciprocal multiply.
  logic [24:0] min_prod;
  logic [5:0]  mins_d;
  logic [11:0] secs_d;

  always_comb begin
    min_prod = 25'(c_rest_q) * 25'(bcdt_pkg::MinRecip);
    mins_d   = min_prod[bcdt_pkg::MinShift+5:bcdt_pkg::MinShift];
    secs_d   = c_rest_q - 12'(12'(mins_d) * 12'd60);
  end

  // Stage E logic: binary digits pairs to BCD.
  logic [7:0] hb, mb, sb;

  always_comb begin
    hb = bcdt_pkg::two_digit_bcd(7'(d_hours_q));
    mb = bcdt_pkg::two_digit_bcd(7'(d_mins_q));
    sb = bcdt_pkg::two_digit_bcd(7'(d_secs_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      alarm_sec_q <= '0;
      armed_q     <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_i.valid;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
      if (e_ready) begin
        e_valid_q <= d_valid_q;
      end
      if (a_fire) begin
        alarm_sec_q <= alarm_sec_d;
        armed_q     <= armed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_i.valid) begin
      a_mode_q  <= in_i.mode;
      a_time_q  <= in_i.time_bcd;
      a_delay_q <= in_i.delay_seconds;
    end
    if (a_fire) begin
      b_alarm_q <= alarm_sec_d;
      b_res_q   <= b_res_d;
    end
    if (c_ready && b_valid_q) begin
      c_hours_q <= hours_c;
      c_rest_q  <= rest_c[11:0];
      c_res_q   <= b_res_q;
    end
    if (d_ready && c_valid_q) begin
      d_hours_q <= c_hours_q;
      d_mins_q  <= mins_d;
      d_secs_q  <= secs_d[5:0];
      d_res_q   <= c_res_q;
    end
    if (e_ready && d_valid_q) begin
      e_alarm_bcd_q <= {hb[5:0], 1'b0, mb[6:0], 1'b0, sb[6:0]};
      e_res_q       <= d_res_q;
    end
  end

  assign out_o.valid             = e_valid_q;
  assign out_o.alarm_bcd         = e_alarm_bcd_q;
  assign out_o.remaining_seconds = e_res_q.remaining;
  assign out_o.alarm_armed       = e_res_q.armed;
  assign out_o.status            = e_res_q.status;

  a_disarmed_no_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.alarm_armed |-> out_o.remaining_seconds == '0)
    else $error("remaining time reported while the alarm is disarmed");

  a_fault_no_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != bcdt_pkg::STATUS_OK |-> out_o.remaining_seconds == '0)
    else $error("remaining time reported on a faulted transaction");

  a_remaining_in_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.remaining_seconds < bcdt_pkg::DaySeconds)
    else $error("remaining time exceeds one day");

  a_stored_alarm_in_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_sec_q < bcdt_pkg::DaySeconds)
    else $error("stored alarm lies outside one day");

endmodule

`default_nettype wire
